// File: sv/nearest_edge_wire_shading_unit_defines.svh
// Assertion macros for the nearest-edge wire shading unit.
// Used by the port checker; needs i_clk and i_rst_n in the including scope.
`ifndef NEAREST_EDGE_WIRE_SHADING_UNIT_DEFINES_SVH
`define NEAREST_EDGE_WIRE_SHADING_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define NEWS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define NEWS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/news_pkg.sv
// Shared constants, payload types and register codes of the wire shading unit.
// No dependencies.
package news_pkg;

    localparam int CoordW = 20;
    localparam int IdxW   = 16;
    localparam int DiffW  = CoordW + 1;
    localparam int VecW   = DiffW + 2;
    localparam int AccW   = 2 * DiffW + 2;
    localparam int SumW   = 2 * VecW + 2;
    localparam int RootW  = SumW / 2;
    localparam int MulW   = (VecW > 33) ? VecW : 33;
    localparam int ProdW  = 2 * MulW;
    localparam int QuotW  = 17;
    localparam int DistW  = 21;
    localparam int CovW   = 16;
    localparam int AddrW  = 5;
    localparam int DataW  = 32;

    localparam logic [DistW-1:0] DIST_INF = '1;
    localparam logic [QuotW-1:0] Q16_ONE  = 17'h10000;

    // Cosine polynomial coefficients, Q2.30
    localparam logic [31:0] COS_A   = 32'd1324675881;
    localparam logic [31:0] COS_B   = 32'd272375555;
    localparam logic [31:0] COS_C   = 32'd22401987;
    localparam logic [31:0] COS_D   = 32'd987048;
    localparam logic [31:0] Q30_ONE = 32'd1073741824;

    // Register indexes
    localparam logic [2:0] REG_WIRE_SIZE = 3'd0;
    localparam logic [2:0] REG_FALLOFF   = 3'd1;
    localparam logic [2:0] REG_INVERT    = 3'd2;
    localparam logic [2:0] REG_OUT_MIN   = 3'd3;
    localparam logic [2:0] REG_OUT_MAX   = 3'd4;

    // Falloff modes
    localparam logic [1:0] FALL_ABS        = 2'd0;
    localparam logic [1:0] FALL_LINEAR     = 2'd1;
    localparam logic [1:0] FALL_RADIAL     = 2'd2;
    localparam logic [1:0] FALL_INV_RADIAL = 2'd3;

    typedef struct packed {
        logic [20:0] wire_size;
        logic [1:0]  falloff_mode;
        logic        invert_output;
        logic [15:0] out_min;
        logic [15:0] out_max;
    } t_cfg;

    typedef struct packed {
        logic signed [CoordW-1:0] point_x;
        logic signed [CoordW-1:0] point_y;
        logic signed [CoordW-1:0] point_z;
        logic signed [CoordW-1:0] start_x;
        logic signed [CoordW-1:0] start_y;
        logic signed [CoordW-1:0] start_z;
        logic signed [CoordW-1:0] end_x;
        logic signed [CoordW-1:0] end_y;
        logic signed [CoordW-1:0] end_z;
        logic [IdxW-1:0]          edge_id;
        logic                     last_edge;
    } t_in_item;

    typedef struct packed {
        logic [DistW-1:0] min_distance;
        logic [IdxW-1:0]  closest_edge;
        logic [CovW-1:0]  coverage;
    } t_out_item;

endpackage

// File: sv/nearest_edge_wire_shading_unit.sv
// Each edge runs through take, MAC, check, divide, offsets, squares, root and update; the
// divide uses the shared restoring divider and the root the square-root unit. A new edge is
// taken only back in idle. An edge clamped to an endpoint or degenerate skips the divide
// and offsets. The last edge of a query adds coverage divide, cosine, remap and emit; linear
// skips the cosine, absolute or zero coverage the divide and cosine; emit waits on output stalls.
// Reset (synchronous, active low): running minimum all ones, index zero, registers default.
module nearest_edge_wire_shading_unit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  news_pkg::t_in_item         i_in,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output news_pkg::t_out_item        o_out,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [news_pkg::AddrW-1:0] paddr,
    input  logic [news_pkg::DataW-1:0] pwdata,
    output logic [news_pkg::DataW-1:0] prdata,
    output logic                       pready
);
    import news_pkg::*;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_MAC    = 4'd1;
    localparam logic [3:0] ST_CHK    = 4'd2;
    localparam logic [3:0] ST_DIV    = 4'd3;
    localparam logic [3:0] ST_OFF    = 4'd4;
    localparam logic [3:0] ST_SQ     = 4'd5;
    localparam logic [3:0] ST_ROOT   = 4'd6;
    localparam logic [3:0] ST_UPD    = 4'd7;
    localparam logic [3:0] ST_COVDIV = 4'd8;
    localparam logic [3:0] ST_COS    = 4'd9;
    localparam logic [3:0] ST_REMAP  = 4'd10;
    localparam logic [3:0] ST_EMIT   = 4'd11;

    t_cfg cfg;

    logic [3:0]               r_state;
    logic [3:0]               r_step;
    logic signed [DiffW-1:0]  r_d [3];
    logic signed [DiffW-1:0]  r_e [3];
    logic signed [DiffW-1:0]  r_f [3];
    logic signed [VecW-1:0]   r_vec [3];
    logic                     r_last;
    logic [IdxW-1:0]          r_id;
    logic signed [AccW-1:0]   r_len2;
    logic signed [AccW-1:0]   r_dot;
    logic [QuotW-1:0]         r_uq;
    logic [SumW-1:0]          r_sum;
    logic [DistW-1:0]         r_min;
    logic [IdxW-1:0]          r_idx;
    logic [QuotW-1:0]         r_x;
    logic [30:0]              r_z;
    logic [31:0]              r_r;
    logic [QuotW-1:0]         r_raw;
    logic [CovW-1:0]          r_cov;
    logic                     r_ovalid;
    t_out_item                r_out;

    logic signed [MulW-1:0]   w_mul_a;
    logic signed [MulW-1:0]   w_mul_b;
    logic signed [ProdW-1:0]  w_prod;
    logic                     w_div_start;
    logic [AccW-1:0]          w_div_num;
    logic [AccW-1:0]          w_div_den;
    logic                     w_div_done;
    logic [QuotW-1:0]         w_quot;
    logic                     w_sqrt_start;
    logic                     w_sqrt_done;
    logic [RootW-1:0]         w_root;

    logic                     w_accept;
    logic                     w_out_free;
    logic signed [DiffW:0]    w_e0_ext;
    logic [DiffW:0]           w_eabs;
    logic [ProdW-1:0]         w_off_sum;
    logic signed [VecW-1:0]   w_off;
    logic signed [VecW-1:0]   w_c;
    logic [DistW-1:0]         w_dist;
    logic [DistW-1:0]         w_cmin;
    logic [IdxW-1:0]          w_cidx;
    logic [DistW-1:0]         w_w;
    logic                     w_cov_zero;
    logic [31:0]              w_k;
    logic [32:0]              w_hp;
    logic signed [33:0]       w_hv;
    logic [32:0]              w_rr;
    logic [QuotW-1:0]         w_cosv;
    logic [QuotW-1:0]         w_rawi;
    logic signed [16:0]       w_diff;
    logic signed [33:0]       w_pr;
    logic [33:0]              w_pm;
    logic [33:0]              w_pq;
    logic [CovW-1:0]          w_mq;
    logic [CovW-1:0]          w_cov;

    // Units
    news_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    news_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    news_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    news_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_sqrt_start),
        .i_rad   (r_sum),
        .o_done  (w_sqrt_done),
        .o_root  (w_root)
    );

    assign o_in_ready  = (r_state == ST_IDLE);
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_out_free  = !r_ovalid || i_out_ready;
    assign o_out_valid = r_ovalid;
    assign o_out       = r_out;

    // Edge offset helpers
    assign w_e0_ext  = {r_e[0][DiffW-1], r_e[0]};
    assign w_eabs    = r_e[0][DiffW-1] ? $unsigned(-w_e0_ext) : $unsigned(w_e0_ext);
    assign w_off_sum = $unsigned(w_prod) + ProdW'(32768);
    assign w_off     = $signed(w_off_sum[VecW+15:16]);
    assign w_c       = VecW'(r_d[0]) - (r_e[0][DiffW-1] ? -w_off : w_off);

    // Distance, running minimum and coverage gating
    assign w_dist     = (w_root > RootW'(DIST_INF)) ? DIST_INF : w_root[DistW-1:0];
    assign w_cmin     = (w_dist < r_min) ? w_dist : r_min;
    assign w_cidx     = (w_dist < r_min) ? r_id : r_idx;
    assign w_w        = (cfg.wire_size == '0) ? DistW'(1) : cfg.wire_size;
    assign w_cov_zero = (w_cmin == DIST_INF) || (w_cmin > w_w);

    // Horner step: k - r*z/2^30, clamped at zero
    always_comb begin
        case (r_step)
            4'd3:    w_k = COS_C;
            4'd5:    w_k = COS_B;
            4'd7:    w_k = COS_A;
            default: w_k = Q30_ONE;
        endcase
    end
    assign w_hp   = $unsigned(w_prod[62:30]);
    assign w_hv   = $signed({2'b00, w_k}) - $signed({1'b0, w_hp});
    assign w_rr   = {1'b0, r_r} + 33'd8192;
    assign w_cosv = (w_rr[32:14] > 19'(Q16_ONE)) ? Q16_ONE : w_rr[30:14];

    // Remap with round half away from zero
    assign w_rawi = cfg.invert_output ? (Q16_ONE - r_raw) : r_raw;
    assign w_diff = $signed({1'b0, cfg.out_max}) - $signed({1'b0, cfg.out_min});
    assign w_pr   = w_prod[33:0];
    assign w_pm   = w_pr[33] ? $unsigned(-w_pr) : $unsigned(w_pr);
    assign w_pq   = w_pm + 34'd32768;
    assign w_mq   = w_pq[31:16];
    assign w_cov  = w_pr[33] ? (cfg.out_min - w_mq) : (cfg.out_min + w_mq);

    // Multiplier operand select
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        case (r_state)
            ST_MAC: begin
                w_mul_a = (r_step < 4'd3) ? MulW'(r_e[0]) : MulW'(r_d[0]);
                w_mul_b = MulW'(r_e[0]);
            end
            ST_OFF: begin
                w_mul_a = MulW'(r_uq);
                w_mul_b = MulW'(w_eabs);
            end
            ST_SQ: begin
                w_mul_a = MulW'(r_vec[0]);
                w_mul_b = MulW'(r_vec[0]);
            end
            ST_COS: begin
                if (r_step == 4'd0) begin
                    w_mul_a = MulW'(r_x);
                    w_mul_b = MulW'(r_x);
                end else begin
                    w_mul_a = MulW'(r_r);
                    w_mul_b = MulW'(r_z);
                end
            end
            ST_REMAP: begin
                w_mul_a = MulW'(w_rawi);
                w_mul_b = MulW'(w_diff);
            end
            default: ;
        endcase
    end

    // Divider launch: projection factor or coverage ratio
    always_comb begin
        w_div_start = 1'b0;
        w_div_num   = $unsigned(r_dot);
        w_div_den   = $unsigned(r_len2);
        if (r_state == ST_CHK) begin
            w_div_start = !((r_len2 == '0) || r_dot[AccW-1] || (r_dot > r_len2));
        end else if (r_state == ST_UPD) begin
            w_div_start = w_sqrt_done ? 1'b0 : (r_last && !w_cov_zero &&
                                                (cfg.falloff_mode != FALL_ABS));
            w_div_num   = (cfg.falloff_mode == FALL_LINEAR) ? AccW'(w_w - w_cmin)
                                                             : AccW'(w_cmin);
            w_div_den   = AccW'(w_w);
        end
    end

    // Root starts once the third square has landed in the sum
    assign w_sqrt_start = (r_state == ST_SQ) && (r_step == 4'd4);

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_step   <= '0;
            r_min    <= DIST_INF;
            r_idx    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            // Result register: set on emit, cleared once taken
            if (r_state == ST_EMIT && w_out_free) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    r_step <= '0;
                    if (w_accept) begin
                        r_state <= ST_MAC;
                    end
                end
                ST_MAC: begin
                    r_step <= r_step + 1'b1;
                    if (r_step == 4'd6) begin
                        r_state <= ST_CHK;
                    end
                end
                ST_CHK: begin
                    r_step <= '0;
                    r_state <= w_div_start ? ST_DIV : ST_SQ;
                end
                ST_DIV: begin
                    r_step <= '0;
                    if (w_div_done) begin
                        r_state <= ST_OFF;
                    end
                end
                ST_OFF: begin
                    if (r_step == 4'd5) begin
                        r_step  <= '0;
                        r_state <= ST_SQ;
                    end else begin
                        r_step <= r_step + 1'b1;
                    end
                end
                ST_SQ: begin
                    r_step <= r_step + 1'b1;
                    if (r_step == 4'd4) begin
                        r_state <= ST_ROOT;
                    end
                end
                ST_ROOT: begin
                    r_step <= r_step + 1'b1;
                    if (w_sqrt_done) begin
                        r_state <= ST_UPD;
                    end
                end
                ST_UPD: begin
                    r_step <= '0;
                    r_min  <= w_cmin;
                    r_idx  <= w_cidx;
                    if (!r_last) begin
                        r_state <= ST_IDLE;
                    end else if (w_cov_zero || cfg.falloff_mode == FALL_ABS) begin
                        r_state <= ST_REMAP;
                    end else begin
                        r_state <= ST_COVDIV;
                    end
                end
                ST_COVDIV: begin
                    r_step <= '0;
                    if (w_div_done) begin
                        r_state <= (cfg.falloff_mode == FALL_LINEAR) ? ST_REMAP : ST_COS;
                    end
                end
                ST_COS: begin
                    if (r_step == 4'd10) begin
                        r_step  <= '0;
                        r_state <= ST_REMAP;
                    end else begin
                        r_step <= r_step + 1'b1;
                    end
                end
                ST_REMAP: begin
                    r_step <= r_step + 1'b1;
                    if (r_step == 4'd1) begin
                        r_state <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    r_step <= r_step + 1'b1;
                    if (w_out_free) begin
                        r_min    <= DIST_INF;
                        r_idx    <= '0;
                        r_state  <= ST_IDLE;
                    end
                end
                default: begin
                    r_step  <= '0;
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                // Take the transaction in: offsets from both endpoints
                r_d[0] <= DiffW'(i_in.point_x) - DiffW'(i_in.start_x);
                r_d[1] <= DiffW'(i_in.point_y) - DiffW'(i_in.start_y);
                r_d[2] <= DiffW'(i_in.point_z) - DiffW'(i_in.start_z);
                r_e[0] <= DiffW'(i_in.end_x) - DiffW'(i_in.start_x);
                r_e[1] <= DiffW'(i_in.end_y) - DiffW'(i_in.start_y);
                r_e[2] <= DiffW'(i_in.end_z) - DiffW'(i_in.start_z);
                r_f[0] <= DiffW'(i_in.point_x) - DiffW'(i_in.end_x);
                r_f[1] <= DiffW'(i_in.point_y) - DiffW'(i_in.end_y);
                r_f[2] <= DiffW'(i_in.point_z) - DiffW'(i_in.end_z);
                r_last <= i_in.last_edge;
                r_id   <= i_in.edge_id;
                r_len2 <= '0;
                r_dot  <= '0;
                r_sum  <= '0;
            end
            ST_MAC: begin
                // len2 from e.e, then dot from d.e; rotate operands under the multiplier
                if (r_step < 4'd6) begin
                    r_e[0] <= r_e[1];
                    r_e[1] <= r_e[2];
                    r_e[2] <= r_e[0];
                end
                if (r_step > 4'd2 && r_step < 4'd6) begin
                    r_d[0] <= r_d[1];
                    r_d[1] <= r_d[2];
                    r_d[2] <= r_d[0];
                end
                if (r_step > 4'd0 && r_step < 4'd4) begin
                    r_len2 <= r_len2 + w_prod[AccW-1:0];
                end else if (r_step > 4'd3) begin
                    r_dot <= r_dot + w_prod[AccW-1:0];
                end
            end
            ST_CHK: begin
                // Clamp to an endpoint where the projection falls outside the edge
                if ((r_len2 == '0) || r_dot[AccW-1]) begin
                    r_vec[0] <= VecW'(r_d[0]);
                    r_vec[1] <= VecW'(r_d[1]);
                    r_vec[2] <= VecW'(r_d[2]);
                end else begin
                    r_vec[0] <= VecW'(r_f[0]);
                    r_vec[1] <= VecW'(r_f[1]);
                    r_vec[2] <= VecW'(r_f[2]);
                end
            end
            ST_DIV: begin
                if (w_div_done) begin
                    r_uq <= w_quot;
                end
            end
            ST_OFF: begin
                // Even step issues u*|e|, odd step forms d - offset and rotates
                if (r_step[0]) begin
                    r_vec[0] <= r_vec[1];
                    r_vec[1] <= r_vec[2];
                    r_vec[2] <= w_c;
                    r_d[0]   <= r_d[1];
                    r_d[1]   <= r_d[2];
                    r_d[2]   <= r_d[0];
                    r_e[0]   <= r_e[1];
                    r_e[1]   <= r_e[2];
                    r_e[2]   <= r_e[0];
                end
            end
            ST_SQ: begin
                // Sum of squares
                if (r_step < 4'd3) begin
                    r_vec[0] <= r_vec[1];
                    r_vec[1] <= r_vec[2];
                    r_vec[2] <= r_vec[0];
                end
                if (r_step > 4'd0 && r_step < 4'd4) begin
                    r_sum <= r_sum + w_prod[SumW-1:0];
                end
            end
            ST_UPD: begin
                if (w_cov_zero) begin
                    r_raw <= '0;
                end else begin
                    r_raw <= Q16_ONE;
                end
            end
            ST_COVDIV: begin
                if (w_div_done) begin
                    r_raw <= w_quot;
                    r_x   <= (cfg.falloff_mode == FALL_RADIAL) ? w_quot : (Q16_ONE - w_quot);
                    r_r   <= COS_D;
                end
            end
            ST_COS: begin
                // x^2/4, four Horner steps, then round to Q1.16
                if (r_step == 4'd1) begin
                    r_z <= w_prod[32:2];
                end else if (r_step > 4'd1 && r_step < 4'd10 && r_step[0]) begin
                    r_r <= w_hv[33] ? 32'd0 : w_hv[31:0];
                end else if (r_step == 4'd10) begin
                    r_raw <= (cfg.falloff_mode == FALL_RADIAL) ? w_cosv : (Q16_ONE - w_cosv);
                end
            end
            ST_REMAP: begin
                if (r_step == 4'd1) begin
                    r_cov <= w_cov;
                end
            end
            ST_EMIT: begin
                if (w_out_free) begin
                    r_out.min_distance <= r_min;
                    r_out.closest_edge <= r_idx;
                    r_out.coverage     <= r_cov;
                end
            end
            default: ;
        endcase
    end

endmodule

// File: sv/news_cfg.sv
// APB-style configuration register file of the wire shading unit.
// Depends on news_pkg.
module news_cfg (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [news_pkg::AddrW-1:0] paddr,
    input  logic [news_pkg::DataW-1:0] pwdata,
    output logic [news_pkg::DataW-1:0] prdata,
    output logic                       pready,
    output news_pkg::t_cfg             o_cfg
);
    import news_pkg::*;

    t_cfg       r_cfg;
    logic [2:0] w_idx;
    logic       w_wr;

    assign pready = 1'b1;
    assign w_idx  = paddr[AddrW-1:2];
    assign w_wr   = psel & penable & pwrite;
    assign o_cfg  = r_cfg;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.wire_size     <= 21'd1024;
            r_cfg.falloff_mode  <= FALL_RADIAL;
            r_cfg.invert_output <= 1'b0;
            r_cfg.out_min       <= 16'd0;
            r_cfg.out_max       <= 16'hFFFF;
        end else if (w_wr) begin
            case (w_idx)
                REG_WIRE_SIZE: r_cfg.wire_size     <= pwdata[20:0];
                REG_FALLOFF:   r_cfg.falloff_mode  <= pwdata[1:0];
                REG_INVERT:    r_cfg.invert_output <= pwdata[0];
                REG_OUT_MIN:   r_cfg.out_min       <= pwdata[15:0];
                REG_OUT_MAX:   r_cfg.out_max       <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Read-back
    always_comb begin
        case (w_idx)
            REG_WIRE_SIZE: prdata = DataW'(r_cfg.wire_size);
            REG_FALLOFF:   prdata = DataW'(r_cfg.falloff_mode);
            REG_INVERT:    prdata = DataW'(r_cfg.invert_output);
            REG_OUT_MIN:   prdata = DataW'(r_cfg.out_min);
            REG_OUT_MAX:   prdata = DataW'(r_cfg.out_max);
            default:       prdata = '0;
        endcase
    end

endmodule

// File: sv/news_mul.sv
// Shared signed multiplier with a registered product.
// Depends on news_pkg.
module news_mul (
    input  logic                              i_clk,
    input  logic signed [news_pkg::MulW-1:0]  i_a,
    input  logic signed [news_pkg::MulW-1:0]  i_b,
    output logic signed [news_pkg::ProdW-1:0] o_prod
);
    import news_pkg::*;

    logic signed [ProdW-1:0] r_prod;

    // Product lands in the cycle after the operands
    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;

endmodule

// File: sv/news_div.sv
// Restoring divider: floor(num * 2^16 / den) for num <= den, one bit a cycle.
// Depends on news_pkg.
module news_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [news_pkg::AccW-1:0] i_num,
    input  logic [news_pkg::AccW-1:0] i_den,
    output logic                      o_done,
    output logic [news_pkg::QuotW-1:0] o_quot
);
    import news_pkg::*;

    localparam int CntW = $clog2(QuotW + 1);

    logic [AccW:0]    r_rem;
    logic [AccW-1:0]  r_den;
    logic [QuotW-1:0] r_quot;
    logic [CntW-1:0]  r_cnt;
    logic             r_busy;
    logic             r_done;
    logic             w_ge;
    logic [AccW:0]    w_rem;

    assign w_ge  = r_rem >= {1'b0, r_den};
    assign w_rem = w_ge ? (r_rem - {1'b0, r_den}) : r_rem;

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= CntW'(QuotW);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CntW'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    // Datapath: compare, subtract, shift
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= {1'b0, i_num};
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem  <= {w_rem[AccW-1:0], 1'b0};
            r_quot <= {r_quot[QuotW-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// File: sv/news_sqrt.sv
// Integer square root, two radicand bits a cycle.
// Depends on news_pkg.
module news_sqrt (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [news_pkg::SumW-1:0]  i_rad,
    output logic                       o_done,
    output logic [news_pkg::RootW-1:0] o_root
);
    import news_pkg::*;

    localparam int CntW = $clog2(RootW + 1);

    logic [SumW-1:0]  r_rad;
    logic [RootW+1:0] r_rem;
    logic [RootW-1:0] r_root;
    logic [CntW-1:0]  r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [RootW+1:0] w_rem2;
    logic [RootW+1:0] w_trial;
    logic             w_ge;

    assign w_rem2  = {r_rem[RootW-1:0], r_rad[SumW-1:SumW-2]};
    assign w_trial = {r_root, 2'b01};
    assign w_ge    = w_rem2 >= w_trial;

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= CntW'(RootW);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CntW'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    // Datapath: one root bit per step
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_rad;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad  <= {r_rad[SumW-3:0], 2'b00};
            r_rem  <= w_ge ? (w_rem2 - w_trial) : w_rem2;
            r_root <= {r_root[RootW-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

// File: sv/news_chk.sv
// Port-level checker for the wire shading unit, bound to the top level.
// Depends on news_pkg and nearest_edge_wire_shading_unit_defines.svh.
`include "nearest_edge_wire_shading_unit_defines.svh"

module news_chk (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic                       o_in_ready,
    input  news_pkg::t_in_item         i_in,
    input  logic                       o_out_valid,
    input  logic                       i_out_ready,
    input  news_pkg::t_out_item        o_out,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [news_pkg::AddrW-1:0] paddr,
    input  logic [news_pkg::DataW-1:0] pwdata,
    input  logic [news_pkg::DataW-1:0] prdata,
    input  logic                       pready
);
    import news_pkg::*;

    // A stalled result holds
    `NEWS_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out), "result changed while stalled")
    // One edge in flight: busy right after a transaction is taken
    `NEWS_ASSERT_NEXT(a_busy, i_in_valid && o_in_ready, !o_in_ready, "input ready straight after a transaction")
    // A query with no finite distance reports edge zero
    `NEWS_ASSERT_NOW(a_inf_idx, o_out_valid && (o_out.min_distance == DIST_INF), o_out.closest_edge == '0, "closest edge set with no finite distance")
    // Register port never waits
    `NEWS_ASSERT_NOW(a_pready, psel && penable, pready, "register access stalled")

endmodule

bind nearest_edge_wire_shading_unit news_chk u_news_chk (.*);

// File: tb/news_scoreboard.sv
// Scoreboard for the nearest-edge wire shading unit: predicts query results and checks them.
// Depends on news_pkg for payload types, register and falloff codes and DIST_INF.
`timescale 1ns / 100ps

class news_scoreboard;

    // Register copy
    logic [20:0] wire_size;
    logic [1:0]  falloff_mode;
    logic        invert_output;
    logic [15:0] out_min;
    logic [15:0] out_max;

    // Per-query running state
    logic [20:0] best_dist;
    logic [15:0] best_edge;

    news_pkg::t_out_item pending_q[$];
    int mismatch_count;

    function void clear_state();
        wire_size     = 21'd1024;
        falloff_mode  = news_pkg::FALL_RADIAL;
        invert_output = 1'b0;
        out_min       = 16'd0;
        out_max       = 16'hFFFF;
        best_dist     = news_pkg::DIST_INF;
        best_edge     = '0;
        pending_q.delete();
        mismatch_count = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] value);
        case (idx)
            news_pkg::REG_WIRE_SIZE: wire_size     = value[20:0];
            news_pkg::REG_FALLOFF:   falloff_mode  = value[1:0];
            news_pkg::REG_INVERT:    invert_output = value[0];
            news_pkg::REG_OUT_MIN:   out_min       = value[15:0];
            news_pkg::REG_OUT_MAX:   out_max       = value[15:0];
            default: ;
        endcase
    endfunction

    // Integer square root, floor
    function longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function logic [20:0] length_of(longint x, longint y, longint z);
        longint unsigned s;
        s = int_sqrt(x * x + y * y + z * z);
        return (s > 64'h1FFFFF) ? news_pkg::DIST_INF : s[20:0];
    endfunction

    // Distance from the point to the clamped projection on the edge
    function logic [20:0] point_edge_dist(news_pkg::t_in_item it);
        longint p[3], a[3], b[3], d[3], e[3], c[3];
        longint len2, dot, frac, off, m;
        p = '{longint'(it.point_x), longint'(it.point_y), longint'(it.point_z)};
        a = '{longint'(it.start_x), longint'(it.start_y), longint'(it.start_z)};
        b = '{longint'(it.end_x), longint'(it.end_y), longint'(it.end_z)};
        len2 = 0;
        dot = 0;
        for (int i = 0; i < 3; i++) begin
            d[i] = p[i] - a[i];
            e[i] = b[i] - a[i];
            len2 += e[i] * e[i];
            dot += d[i] * e[i];
        end
        if (len2 == 0 || dot < 0) return length_of(d[0], d[1], d[2]);
        if (dot > len2) return length_of(p[0] - b[0], p[1] - b[1], p[2] - b[2]);
        frac = (dot * 65536) / len2;
        for (int i = 0; i < 3; i++) begin
            m = (e[i] < 0) ? -e[i] : e[i];
            off = (frac * m + 32768) >>> 16;
            if (e[i] < 0) off = -off;
            c[i] = d[i] - off;
        end
        return length_of(c[0], c[1], c[2]);
    endfunction

    function longint poly_step(longint k, longint r, longint z);
        longint v;
        v = k - ((r * z) >>> 30);
        return (v < 0) ? 0 : v;
    endfunction

    // cos(pi/2 * x), Q1.16 in and out
    function longint cosine_q16(longint x);
        longint z, r;
        if (x > 65536) x = 65536;
        z = (x * x) >>> 2;
        r = 987048;
        r = poly_step(22401987, r, z);
        r = poly_step(272375555, r, z);
        r = poly_step(1324675881, r, z);
        r = poly_step(1073741824, r, z);
        r = (r + 8192) >>> 14;
        return (r > 65536) ? 65536 : r;
    endfunction

    function logic [15:0] coverage_for(logic [20:0] d_in);
        longint w, raw, t, prod, q;
        w = (wire_size == 0) ? 1 : longint'(wire_size);
        raw = 0;
        if (d_in != news_pkg::DIST_INF && longint'(d_in) <= w) begin
            t = (longint'(d_in) * 65536) / w;
            case (falloff_mode)
                news_pkg::FALL_ABS:    raw = 65536;
                news_pkg::FALL_LINEAR: raw = ((w - longint'(d_in)) * 65536) / w;
                news_pkg::FALL_RADIAL: raw = cosine_q16(t);
                default:               raw = 65536 - cosine_q16(65536 - t);
            endcase
        end
        if (invert_output) raw = 65536 - raw;
        prod = raw * (longint'(out_max) - longint'(out_min));
        if (prod >= 0) q = (prod + 32768) >>> 16;
        else q = -((-prod + 32768) >>> 16);
        q = longint'(out_min) + q;
        return q[15:0];
    endfunction

    // Note an accepted edge; queue a result on the last edge of a query
    function void note_edge(news_pkg::t_in_item it);
        logic [20:0] edge_d;
        news_pkg::t_out_item res;
        edge_d = point_edge_dist(it);
        if (edge_d < best_dist) begin
            best_dist = edge_d;
            best_edge = it.edge_id;
        end
        if (it.last_edge) begin
            res.min_distance = best_dist;
            res.closest_edge = best_edge;
            res.coverage     = coverage_for(best_dist);
            pending_q.push_back(res);
            best_dist = news_pkg::DIST_INF;
            best_edge = '0;
        end
    endfunction

    function void report(string what, logic [31:0] exp_v, logic [31:0] act_v);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch %s: expected %0d, got %0d", what, exp_v, act_v);
    endfunction

    function void check_result(news_pkg::t_out_item got);
        news_pkg::t_out_item want;
        if (pending_q.size() == 0) begin
            report("unexpected result, distance", 0, got.min_distance);
            return;
        end
        want = pending_q.pop_front();
        if (got.min_distance != want.min_distance)
            report("min_distance", want.min_distance, got.min_distance);
        if (got.closest_edge != want.closest_edge)
            report("closest_edge", want.closest_edge, got.closest_edge);
        if (got.coverage != want.coverage)
            report("coverage", want.coverage, got.coverage);
    endfunction

endclass

// File: tb/tb.sv
// Top-level testbench of the nearest-edge wire shading unit: stimulus, APB writes, checking.
// Depends on news_pkg, news_scoreboard and the unit's RTL.
`timescale 1ns / 100ps

module tb;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_ready;
    news_pkg::t_in_item  i_in;
    logic                o_out_valid;
    logic                i_out_ready;
    news_pkg::t_out_item o_out;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [news_pkg::AddrW-1:0] paddr;
    logic [news_pkg::DataW-1:0] pwdata;
    logic [news_pkg::DataW-1:0] prdata;
    logic                pready;

    news_scoreboard sb;

    int  send_idle_pct;
    int  recv_stall_pct;
    bit  hold_off;
    int  queries_sent;

    nearest_edge_wire_shading_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // 4 ns clock
    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // Receiver: random stall, long hold-off on request
    always @(negedge i_clk) begin
        if (!i_rst_n || hold_off)
            i_out_ready <= 1'b0;
        else
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Result checking at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_result(o_out);
    end

    // Fixed time limit
    initial begin
        #60ms;
        $display("** nearest_edge_wire_shading_unit: FAILED **");
        $finish;
    end

    task automatic apb_write(logic [2:0] idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= news_pkg::AddrW'(idx) << 2;
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.write_reg(idx, value);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic set_config(logic [20:0] ws, logic [1:0] fm, logic inv,
                              logic [15:0] lo, logic [15:0] hi);
        apb_write(news_pkg::REG_WIRE_SIZE, 32'(ws));
        apb_write(news_pkg::REG_FALLOFF, 32'(fm));
        apb_write(news_pkg::REG_INVERT, 32'(inv));
        apb_write(news_pkg::REG_OUT_MIN, 32'(lo));
        apb_write(news_pkg::REG_OUT_MAX, 32'(hi));
    endtask

    // Offer one edge, with optional random idle first; called at a falling edge
    task automatic send_edge(news_pkg::t_in_item it);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
            @(negedge i_clk);
        i_in       <= it;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_edge(it);
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // Wait for every result, then let the block settle
    task automatic drain();
        while (sb.pending_q.size() != 0) @(negedge i_clk);
        repeat (150) @(negedge i_clk);
    endtask

    function automatic logic signed [19:0] rand_coord(int span);
        int v;
        case ($urandom_range(9))
            0:       return $urandom_range(1) ? 20'sh7FFFF : 20'sh80000;
            1:       return 20'($urandom);
            default: begin
                v = $urandom_range(2 * span) - span;
                return 20'(v);
            end
        endcase
    endfunction

    // One query of random edges around a shared point
    task automatic send_query(int n_edges, int span);
        news_pkg::t_in_item it;
        logic signed [19:0] px, py, pz;
        px = rand_coord(span);
        py = rand_coord(span);
        pz = rand_coord(span);
        for (int k = 0; k < n_edges; k++) begin
            it.point_x = px;
            it.point_y = py;
            it.point_z = pz;
            it.start_x = px + 20'(int'($urandom_range(2 * span)) - span);
            it.start_y = py + 20'(int'($urandom_range(2 * span)) - span);
            it.start_z = pz + 20'(int'($urandom_range(2 * span)) - span);
            if ($urandom_range(11) == 0) begin
                it.end_x = it.start_x;
                it.end_y = it.start_y;
                it.end_z = it.start_z;
            end else begin
                it.end_x = rand_coord(span) + px;
                it.end_y = rand_coord(span) + py;
                it.end_z = rand_coord(span) + pz;
            end
            if ($urandom_range(15) == 0) it.end_x = it.start_x;
            it.edge_id   = 16'($urandom);
            it.last_edge = (k == n_edges - 1);
            if ($urandom_range(19) == 0 && k > 0) it = '{default: '0, edge_id: 16'($urandom),
                last_edge: it.last_edge, point_x: px, point_y: py, point_z: pz};
            send_edge(it);
        end
        queries_sent++;
    endtask

    task automatic directed_edge(logic signed [19:0] p, logic signed [19:0] s,
                                 logic signed [19:0] e, logic [15:0] id, logic last);
        news_pkg::t_in_item it;
        it.point_x = p; it.point_y = -p; it.point_z = p;
        it.start_x = s; it.start_y = s;  it.start_z = -s;
        it.end_x   = e; it.end_y   = -e; it.end_z   = e;
        it.edge_id = id;
        it.last_edge = last;
        send_edge(it);
    endtask

    initial begin
        sb = new();
        sb.clear_state();
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_in           = '0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        hold_off       = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        queries_sent   = 0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: field extremes, degenerate edge, clamping, ties, saturation
        directed_edge(20'sd0, 20'sd100, 20'sd100, 16'd5, 1'b0);
        directed_edge(20'sd0, 20'sd100, 20'sd100, 16'd9, 1'b1);
        directed_edge(20'sd0, -20'sd500, 20'sd500, 16'hFFFF, 1'b1);
        directed_edge(20'sd0, 20'sd300, 20'sd900, 16'd1, 1'b1);
        directed_edge(20'sd2000, 20'sd300, 20'sd900, 16'd2, 1'b1);
        directed_edge(20'sh7FFFF, 20'sh80000, 20'sh80000, 16'd3, 1'b1);
        directed_edge(20'sh80000, 20'sh7FFFF, 20'sh80000, 16'hFFFF, 1'b0);
        directed_edge(20'sh7FFFF, 20'sh80000, 20'sh7FFFF, 16'd0, 1'b1);
        directed_edge(20'sd10, 20'sd0, 20'sd0, 16'd7, 1'b1);
        drain();
        set_config(21'd1, news_pkg::FALL_ABS, 1'b1, 16'hFFFF, 16'd0);
        directed_edge(20'sd0, 20'sd0, 20'sd0, 16'd4, 1'b1);
        directed_edge(20'sd1, 20'sd0, 20'sd0, 16'd4, 1'b1);
        drain();
        set_config(21'h1FFFFF, news_pkg::FALL_LINEAR, 1'b0, 16'd0, 16'hFFFF);
        directed_edge(20'sd50000, -20'sd3, 20'sd7, 16'd8, 1'b1);
        directed_edge(20'sh80000, 20'sh7FFFF, 20'sh7FFFF, 16'd8, 1'b1);
        drain();
        set_config(21'd0, news_pkg::FALL_INV_RADIAL, 1'b0, 16'd100, 16'd60000);
        directed_edge(20'sd0, 20'sd0, 20'sd1, 16'd2, 1'b1);
        drain();

        // Random phases: vary config and idling between phases
        for (int ph = 0; ph < 8; ph++) begin
            int span;
            set_config(($urandom_range(3) == 0) ? 21'($urandom) : 21'($urandom_range(8000, 1)),
                       2'(ph), 1'($urandom), 16'($urandom), 16'($urandom));
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
                default: begin send_idle_pct = 37; recv_stall_pct = 37; end
            endcase
            if (ph == 2) begin
                // Receiver hold-off while the sender keeps offering edges
                fork
                    begin
                        hold_off = 1'b1;
                        repeat (3000) @(negedge i_clk);
                        hold_off = 1'b0;
                    end
                join_none
            end
            while (queries_sent < (ph + 1) * 42) begin
                span = ($urandom_range(3) == 0) ? 200000 : $urandom_range(8000, 4);
                send_query($urandom_range(4, 1), span);
            end
            // Sender pause until all results are back
            drain();
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;
        drain();

        if (sb.mismatch_count == 0 && sb.pending_q.size() == 0)
            $display("** nearest_edge_wire_shading_unit: PASSED **");
        else
            $display("** nearest_edge_wire_shading_unit: FAILED **");
        $finish;
    end

endmodule
